FILE: rtl/core/epvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epvg_pkg;

  // Field widths of the stream beats.
  localparam int unsigned COORD_W    = 26;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned NUM_W      = 6;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned IN_DATA_W  = 208;
  localparam int unsigned OUT_DATA_W = 80;

  // Angle and sine formats: angles in 1024ths of a turn, sines in signed 2.8.
  localparam int unsigned ANG_W   = 10;
  localparam int unsigned TRIG_W  = 10;
  localparam int unsigned TURN    = 1024;
  localparam int unsigned QUARTER = 256;

  // Step divider for TURN / n: one quotient bit per cycle.
  localparam int unsigned DIVQ_W    = 11;
  localparam int unsigned DIV_STEPS = 11;
  localparam int unsigned DCNT_W    = 4;

  // Segment count rule.
  localparam int unsigned SEG_BASE         = 12;
  localparam int unsigned MAX_SEGMENTS_DEF = 48;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic size;
    logic count;
    logic div_step;
    logic trig;
    logic mul1;
    logic emit;
  } epvg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic radius_bad;
    logic count_zero;
    logic div_last;
    logic out_free;
    logic last;
  } epvg_sts_t;

  // Quarter-wave sine table, 16 intervals plus the end point.
  function automatic logic [8:0] quarter_sine(input logic [4:0] idx);
    logic [8:0] v;
    case (idx)
      5'd0:    v = 9'd0;
      5'd1:    v = 9'd25;
      5'd2:    v = 9'd50;
      5'd3:    v = 9'd74;
      5'd4:    v = 9'd98;
      5'd5:    v = 9'd121;
      5'd6:    v = 9'd142;
      5'd7:    v = 9'd162;
      5'd8:    v = 9'd181;
      5'd9:    v = 9'd198;
      5'd10:   v = 9'd213;
      5'd11:   v = 9'd226;
      5'd12:   v = 9'd237;
      5'd13:   v = 9'd245;
      5'd14:   v = 9'd251;
      5'd15:   v = 9'd255;
      default: v = 9'd256;
    endcase
    return v;
  endfunction

  // Interpolated sine of an angle in 1024ths of a turn, signed 2.8.
  function automatic logic signed [TRIG_W-1:0] turn_sine(input logic [ANG_W-1:0] a);
    logic [1:0]                quad;
    logic [8:0]                t;
    logic [4:0]                idx;
    logic [4:0]                idx_n;
    logic [3:0]                fr;
    logic [8:0]                v0;
    logic [8:0]                v1;
    logic [12:0]               slope;
    logic [8:0]                mag;
    logic signed [TRIG_W-1:0]  s;
    quad = a[ANG_W-1:ANG_W-2];
    t    = {1'b0, a[ANG_W-3:0]};
    if (quad[0]) begin
      t = 9'(QUARTER) - t;
    end
    idx   = t[8:4];
    fr    = t[3:0];
    idx_n = (idx == 5'd16) ? idx : idx + 5'd1;
    v0    = quarter_sine(idx);
    v1    = quarter_sine(idx_n);
    slope = 13'(v1 - v0) * 13'(fr);
    mag   = v0 + slope[12:4];
    s     = signed'({1'b0, mag});
    return quad[1] ? -s : s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/epvg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module epvg_ctrl
  import epvg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire epvg_sts_t sts_i,
  output epvg_cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SIZE  = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_TRIG  = 3'd4;
  localparam logic [2:0] ST_MUL1  = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SIZE;
        end
      end
      ST_SIZE: begin
        if (sts_i.radius_bad) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.size = 1'b1;
          state_d    = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (sts_i.count_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.count = 1'b1;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_TRIG;
        end
      end
      ST_TRIG: begin
        cmd_o.trig = 1'b1;
        state_d    = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last ? ST_IDLE : ST_TRIG;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/epvg_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module epvg_dp
  import epvg_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned CNT_W        = $clog2(MAX_SEGMENTS + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire epvg_cmd_t                  cmd_i,
  output epvg_sts_t                       sts_o,
  input  wire logic signed [COORD_W-1:0]  center_x_i,
  input  wire logic signed [COORD_W-1:0]  center_y_i,
  input  wire logic signed [COORD_W-1:0]  radius_x_i,
  input  wire logic signed [COORD_W-1:0]  radius_y_i,
  input  wire logic                       is_circle_i,
  input  wire logic signed [COORD_W-1:0]  scale_x_i,
  input  wire logic signed [COORD_W-1:0]  scale_y_i,
  input  wire logic signed [COORD_W-1:0]  offset_x_i,
  input  wire logic signed [COORD_W-1:0]  offset_y_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic signed [POS_W-1:0]         vertex_x_o,
  output logic signed [POS_W-1:0]         vertex_y_o,
  output logic [NUM_W-1:0]                vertex_number_o,
  output logic [NUM_W-1:0]                vertex_total_o,
  output logic                            last_vertex_o
);

  localparam int unsigned SIZE_W = 2 * COORD_W;
  localparam int unsigned RT_W   = COORD_W + TRIG_W;
  localparam int unsigned US_W   = POS_W + COORD_W;
  localparam int unsigned RTS_W  = RT_W - FRAC_W;
  localparam int unsigned EXT_W  = POS_W - COORD_W;
  localparam int unsigned NF_W   = POS_W - FRAC_W + 1;

  // Captured shape parameters.
  logic signed [COORD_W-1:0] cx_q, cy_q, rx_q, ry_q;
  logic signed [COORD_W-1:0] sx_q, sy_q, tx_q, ty_q;

  // Size product, count, divider and angle stepping.
  logic signed [SIZE_W-1:0]  prod_q;
  logic [CNT_W-1:0]          n_q;
  logic [DIVQ_W-1:0]         div_q;
  logic [CNT_W-1:0]          drem_q;
  logic [DCNT_W-1:0]         dcnt_q;
  logic [DIVQ_W-1:0]         ang_q;
  logic [CNT_W-1:0]          arem_q;
  logic [CNT_W-1:0]          idx_q;

  // Per-vertex working registers.
  logic signed [TRIG_W-1:0]  sin_q, cos_q;
  logic signed [POS_W-1:0]   ux_q, uy_q;

  // Output register.
  logic                      out_valid_q;
  logic signed [POS_W-1:0]   out_x_q, out_y_q;
  logic [NUM_W-1:0]          out_num_q, out_tot_q;
  logic                      out_last_q;

  // Combinational helpers.
  logic signed [COORD_W-1:0] ry_sel;
  logic signed [COORD_W-1:0] r_max;
  logic signed [SIZE_W-1:0]  size_prod;
  logic signed [NF_W-2:0]    big;
  logic signed [NF_W-1:0]    big_adj;
  logic signed [NF_W-1:0]    n_full;
  logic [CNT_W-1:0]          n_next;
  logic [CNT_W:0]            div_sh;
  logic                      div_ge;
  logic [CNT_W:0]            arem_sum;
  logic                      arem_wrap;
  logic [ANG_W-1:0]          cos_ang;
  logic signed [RT_W-1:0]    rx_cos, ry_sin;
  logic signed [POS_W-1:0]   ux_d, uy_d;
  logic signed [US_W-1:0]    ux_sx, uy_sy;
  logic signed [POS_W-1:0]   out_x_d, out_y_d;
  logic [CNT_W+NUM_W-1:0]    idx_ext, n_ext;
  logic                      is_last;

  // Radius choice and segment count from the larger radius.
  always_comb begin
    ry_sel    = is_circle_i ? radius_x_i : radius_y_i;
    r_max     = (rx_q > ry_q) ? rx_q : ry_q;
    size_prod = r_max * sx_q;
    // Two arithmetic shifts by eight, then a halving that truncates toward zero.
    big       = prod_q[POS_W+FRAC_W-1:2*FRAC_W];
    big_adj   = {big[NF_W-2], big} + NF_W'(big[NF_W-2]);
    n_full    = (big_adj >>> 1) + signed'(NF_W'(SEG_BASE));
    n_next    = (n_full > signed'(NF_W'(MAX_SEGMENTS))) ? CNT_W'(MAX_SEGMENTS)
                                                        : n_full[CNT_W-1:0];
  end

  // Restoring divider step and angle accumulation.
  always_comb begin
    div_sh    = {drem_q, div_q[DIVQ_W-1]};
    div_ge    = (div_sh >= {1'b0, n_q});
    arem_sum  = {1'b0, arem_q} + {1'b0, drem_q};
    arem_wrap = (arem_sum >= {1'b0, n_q});
  end

  // Vertex arithmetic.
  always_comb begin
    cos_ang = ang_q[ANG_W-1:0] + ANG_W'(QUARTER);
    rx_cos  = rx_q * cos_q;
    ry_sin  = ry_q * sin_q;
    ux_d    = {{(POS_W-RTS_W){rx_cos[RT_W-1]}}, rx_cos[RT_W-1:FRAC_W]}
            + {{EXT_W{cx_q[COORD_W-1]}}, cx_q};
    uy_d    = {{(POS_W-RTS_W){ry_sin[RT_W-1]}}, ry_sin[RT_W-1:FRAC_W]}
            + {{EXT_W{cy_q[COORD_W-1]}}, cy_q};
    ux_sx   = ux_q * sx_q;
    uy_sy   = uy_q * sy_q;
    out_x_d = ux_sx[POS_W+FRAC_W-1:FRAC_W] + {{EXT_W{tx_q[COORD_W-1]}}, tx_q};
    out_y_d = uy_sy[POS_W+FRAC_W-1:FRAC_W] + {{EXT_W{ty_q[COORD_W-1]}}, ty_q};
    idx_ext = {{NUM_W{1'b0}}, idx_q};
    n_ext   = {{NUM_W{1'b0}}, n_q};
    is_last = (({1'b0, idx_q} + (CNT_W+1)'(1)) == {1'b0, n_q});
  end

  // Status toward the controller.
  always_comb begin
    sts_o.radius_bad = (rx_q <= 0) || (ry_q <= 0);
    sts_o.count_zero = (n_full <= 0);
    sts_o.div_last   = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.last       = is_last;
  end

  // Control counters and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
      idx_q       <= '0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.count) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      if (cmd_i.count) begin
        idx_q <= '0;
      end else if (cmd_i.emit) begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      rx_q <= radius_x_i;
      ry_q <= ry_sel;
      sx_q <= scale_x_i;
      sy_q <= scale_y_i;
      tx_q <= offset_x_i;
      ty_q <= offset_y_i;
    end
    if (cmd_i.size) begin
      prod_q <= size_prod;
    end
    if (cmd_i.count) begin
      n_q    <= n_next;
      div_q  <= DIVQ_W'(TURN);
      drem_q <= '0;
      ang_q  <= '0;
      arem_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_q  <= {div_q[DIVQ_W-2:0], div_ge};
      drem_q <= div_ge ? CNT_W'(div_sh - {1'b0, n_q}) : div_sh[CNT_W-1:0];
    end
    if (cmd_i.trig) begin
      sin_q <= turn_sine(ang_q[ANG_W-1:0]);
      cos_q <= turn_sine(cos_ang);
    end
    if (cmd_i.mul1) begin
      ux_q <= ux_d;
      uy_q <= uy_d;
    end
    if (cmd_i.emit) begin
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_num_q  <= idx_ext[NUM_W-1:0];
      out_tot_q  <= n_ext[NUM_W-1:0];
      out_last_q <= is_last;
      // Next angle is the running quotient of i * TURN / n.
      if (arem_wrap) begin
        arem_q <= CNT_W'(arem_sum - {1'b0, n_q});
        ang_q  <= ang_q + div_q + DIVQ_W'(1);
      end else begin
        arem_q <= arem_sum[CNT_W-1:0];
        ang_q  <= ang_q + div_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vertex_x_o      = out_x_q;
  assign vertex_y_o      = out_y_q;
  assign vertex_number_o = out_num_q;
  assign vertex_total_o  = out_tot_q;
  assign last_vertex_o   = out_last_q;

  // A vertex is only written into a free or draining output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("vertex written over a held output beat");

  // The vertex index stays below the count while emitting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (idx_q < n_q))
    else $error("vertex index ran past the vertex count");

  // The angle remainder stays below the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.trig |-> (arem_q < n_q))
    else $error("angle remainder not reduced");

endmodule

`default_nettype wire

FILE: rtl/core/ellipse_polygon_vertex_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Bits  Contents
// s_axis    in   208   one shape per beat; tuser carries is_circle
// m_axis    out  80    one polygon vertex per beat; tlast marks the final vertex
//
// A shape's setup is capture, size product, count and an 11-step divider
// for 1024 / n, then each vertex takes a table lookup, a radius product and
// a scale product, in that order.
// A shape with a non-positive radius or count ends before the divider.
// The input is taken only between shapes; a stalled output holds the last
// vertex in its register and the sequencer waits before writing the next.
// Reset is asynchronous and clears the sequencer and the output valid flag.

module ellipse_polygon_vertex_generator_top
  import epvg_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // center_x, center_y, radius_x, radius_y, scale_x, scale_y, offset_x, offset_y
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // is_circle
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // vertex_x, vertex_y, vertex_number, vertex_total, zero padding
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast
);

  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned PAD_W = OUT_DATA_W - 2 * POS_W - 2 * NUM_W;

  epvg_cmd_t cmd;
  epvg_sts_t sts;

  logic signed [POS_W-1:0] vertex_x;
  logic signed [POS_W-1:0] vertex_y;
  logic [NUM_W-1:0]        vertex_number;
  logic [NUM_W-1:0]        vertex_total;

  // Sequencer.
  epvg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and output register.
  epvg_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .CNT_W        (CNT_W)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .center_x_i      (s_axis_tdata[1*COORD_W-1:0*COORD_W]),
    .center_y_i      (s_axis_tdata[2*COORD_W-1:1*COORD_W]),
    .radius_x_i      (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
    .radius_y_i      (s_axis_tdata[4*COORD_W-1:3*COORD_W]),
    .is_circle_i     (s_axis_tuser),
    .scale_x_i       (s_axis_tdata[5*COORD_W-1:4*COORD_W]),
    .scale_y_i       (s_axis_tdata[6*COORD_W-1:5*COORD_W]),
    .offset_x_i      (s_axis_tdata[7*COORD_W-1:6*COORD_W]),
    .offset_y_i      (s_axis_tdata[8*COORD_W-1:7*COORD_W]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .vertex_x_o      (vertex_x),
    .vertex_y_o      (vertex_y),
    .vertex_number_o (vertex_number),
    .vertex_total_o  (vertex_total),
    .last_vertex_o   (m_axis_tlast)
  );

  // Output beat packing.
  assign m_axis_tdata = {{PAD_W{1'b0}}, vertex_total, vertex_number, vertex_y, vertex_x};

endmodule

`default_nettype wire
